### rtl/core/oale_pkg.sv
package oale_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  // Field widths fixed by the interface.
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int FOUND_W  = 4;
  localparam int CFG_W    = 5;

  // Widths that follow from the store size.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W = $clog2(CAPACITY + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_SET    = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]           operation;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } oale_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [CFG_W-1:0]    list_length;
  } oale_rsp_t;

endpackage

### rtl/core/ordered_array_list_engine.sv
// Set, clear, undefined codes and rejected requests go from acceptance straight to S_DONE,
// which loads the response register once the output is free; insert, remove and find walk first.
// Throughput: one request at a time; the entry walk runs one store entry per cycle through
// the single-read, single-write entry RAM. A new request is taken while a response
// still waits.
// Reset: length clears to zero and capacity_in_use returns to 16; entries are not cleared.
module ordered_array_list_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  oale_pkg::oale_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output oale_pkg::oale_rsp_t out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_data_i
);
  import oale_pkg::*;

  localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int CW    = (CFG_W > LEN_W) ? CFG_W : LEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_FIND,
    S_DONE
  } state_e;

  state_e                state_q, state_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [CFG_W-1:0]      cap_q;
  logic [DATA_WIDTH-1:0] word_q, word_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [IDX_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]      rd_addr_q, rd_addr_d;
  logic                  iss_q, iss_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [STATUS_W-1:0]   stat_q, stat_d;
  logic [FOUND_W-1:0]    found_q, found_d;
  logic                  out_valid_q, out_valid_d;
  oale_rsp_t             rsp_q, rsp_d;

  logic                  in_accept;
  logic                  list_full;
  logic                  pos_gt_len, pos_ge_len, pos_is_last;
  logic [IDX_W-1:0]      last_idx;
  logic                  mem_we, rd_en;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign list_full   = (CW'(len_q) >= CW'(cap_q)) || (len_q >= LEN_W'(CAPACITY));
  assign pos_gt_len  = CMP_W'(in_req_i.position) > CMP_W'(len_q);
  assign pos_ge_len  = CMP_W'(in_req_i.position) >= CMP_W'(len_q);
  assign last_idx    = IDX_W'(len_q - 1'b1);
  assign pos_is_last = CMP_W'(in_req_i.position) == CMP_W'(len_q - 1'b1);

  oale_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    word_d      = word_q;
    pos_d       = pos_q;
    rd_ptr_d    = rd_ptr_q;
    rd_addr_d   = rd_ptr_q;
    iss_d       = iss_q;
    rd_pend_d   = 1'b0;
    stat_d      = stat_q;
    found_d     = found_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = word_q;
    rd_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          word_d  = in_req_i.value[DATA_WIDTH-1:0];
          pos_d   = IDX_W'(in_req_i.position);
          stat_d  = ST_OK;
          found_d = '0;
          state_d = S_DONE;
          priority if (in_req_i.operation == OP_INSERT) begin
            if (list_full) begin
              stat_d = ST_FULL;
            end else if (pos_gt_len) begin
              stat_d = ST_BADPOS;
            end else begin
              // Walk down from the tail; an insert at the end skips the walk.
              rd_ptr_d = last_idx;
              iss_d    = pos_ge_len ? 1'b0 : 1'b1;
              state_d  = S_INS;
            end
          end else if (in_req_i.operation == OP_REMOVE) begin
            if (len_q == '0) begin
              stat_d = ST_EMPTY;
            end else if (pos_ge_len) begin
              stat_d = ST_BADPOS;
            end else begin
              rd_ptr_d = IDX_W'(in_req_i.position) + 1'b1;
              iss_d    = !pos_is_last;
              state_d  = S_REM;
            end
          end else if (in_req_i.operation == OP_SET) begin
            if (pos_ge_len) begin
              stat_d = ST_BADPOS;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = IDX_W'(in_req_i.position);
              mem_wdata = in_req_i.value[DATA_WIDTH-1:0];
            end
          end else if (in_req_i.operation == OP_FIND) begin
            if (len_q == '0) begin
              stat_d = ST_NOTFOUND;
            end else begin
              rd_ptr_d = '0;
              iss_d    = 1'b1;
              state_d  = S_FIND;
            end
          end else if (in_req_i.operation == OP_CLEAR) begin
            len_d = '0;
          end else begin
            // Undefined codes leave the list unchanged and answer ST_OK.
          end
        end
      end

      S_INS: begin
        // Entry read at k is written to k+1 while k-1 is being read.
        if (rd_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q + 1'b1;
          mem_wdata = mem_rdata;
        end
        if (iss_q) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          if (rd_ptr_q == pos_q) begin
            iss_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q - 1'b1;
          end
        end
        if (!iss_q && !rd_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q;
          mem_wdata = word_q;
          len_d     = len_q + 1'b1;
          state_d   = S_DONE;
        end
      end

      S_REM: begin
        if (rd_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q - 1'b1;
          mem_wdata = mem_rdata;
        end
        if (iss_q) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          if (rd_ptr_q == last_idx) begin
            iss_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + 1'b1;
          end
        end
        if (!iss_q && !rd_pend_q) begin
          len_d   = len_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_FIND: begin
        if (iss_q) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          if (rd_ptr_q == last_idx) begin
            iss_d = 1'b0;
          end else begin
            rd_ptr_d = rd_ptr_q + 1'b1;
          end
        end
        if (rd_pend_q) begin
          if (mem_rdata == word_q) begin
            stat_d    = ST_OK;
            found_d   = FOUND_W'(rd_addr_q);
            iss_d     = 1'b0;
            rd_pend_d = 1'b0;
            state_d   = S_DONE;
          end else if (rd_addr_q == last_idx) begin
            stat_d  = ST_NOTFOUND;
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          rsp_d.status      = stat_q;
          rsp_d.found_index = found_q;
          rsp_d.list_length = CFG_W'(len_q);
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      cap_q       <= CAP_RESET;
      iss_q       <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      iss_q       <= iss_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    pos_q     <= pos_d;
    rd_ptr_q  <= rd_ptr_d;
    rd_addr_q <= rd_addr_d;
    stat_q    <= stat_d;
    found_q   <= found_d;
    rsp_q     <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("list length exceeds the store size");

  a_shift_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && rd_en) |-> (mem_waddr != rd_ptr_q))
    else $error("shift writes the entry it is reading");

  a_find_keeps_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |=> $stable(len_q))
    else $error("find changed the list length");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q != S_IDLE))
    else $error("accepted request produced no work");

  a_done_loads_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished request did not reach the output register");

endmodule

### rtl/core/oale_ram.sv
module oale_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
